FILE: rtl/pard_pkg.sv
`timescale 1ns / 1ps

package pard_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_ADDR_BITS   = 16;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_REMOVE  = 3'd1;
   localparam logic [2:0] OP_RD_BYTE = 3'd2;
   localparam logic [2:0] OP_RD_WORD = 3'd3;
   localparam logic [2:0] OP_WR_BYTE = 3'd4;
   localparam logic [2:0] OP_WR_WORD = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_ID    = 2'd2;
   localparam logic [1:0] ST_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  mapping_id;
      logic [7:0]  device_id;
      logic [15:0] range_start;
      logic [15:0] range_end;
      logic [15:0] address;
      logic [15:0] write_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  target_device;
      logic [1:0]  access_kind;
      logic [15:0] access_address;
      logic [15:0] access_data;
      logic [7:0]  root_device;
      logic [4:0]  entries_used;
   } rsp_type;

endpackage

FILE: rtl/pard_table.sv
`timescale 1ns / 1ps

module pard_table
   import pard_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_ENTRIES,
   parameter int WIDTH = 16 + 2 * DEF_ADDR_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pard_match.sv
`timescale 1ns / 1ps

module pard_match
   import pard_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic [16+2*ADDR_BITS-1:0] entry,
   input  logic                      by_id,
   input  logic [7:0]                key_id,
   input  logic [ADDR_BITS-1:0]      key_addr,
   output logic                      hit,
   output logic [7:0]                device
);

   // An entry is packed as mapping id, device id, first address, last address.
   localparam int ENTRY_W = 16 + 2 * ADDR_BITS;

   logic [7:0]           entry_id;
   logic [ADDR_BITS-1:0] entry_start;
   logic [ADDR_BITS-1:0] entry_end;

   assign entry_id    = entry[ENTRY_W-1 -: 8];
   assign device      = entry[ENTRY_W-9 -: 8];
   assign entry_start = entry[2*ADDR_BITS-1 -: ADDR_BITS];
   assign entry_end   = entry[ADDR_BITS-1:0];

   always_comb begin
      if (by_id) begin
         hit = (entry_id == key_id);
      end else begin
         hit = (entry_start <= key_addr) && (key_addr <= entry_end);
      end
   end

endmodule

FILE: rtl/priority_address_range_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_stall
// rsp      out        rsp_type  rsp_valid / rsp_stall
//
// The table sits in a memory with one read and one write port, and a single compare
// unit checks one entry per cycle. rsp_valid rises after the walk, a read of the last
// entry for the root device and a registered result; a walk covers at most MAX_ENTRIES
// entries, an add then writes its entry, and a full-table add or unused code walks none.
// Reset empties the table at once; entries are never cleared. The block takes one
// transaction at a time, holds req_stall high until the result is taken, and holds it.

module priority_address_range_decoder
   import pard_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int ENTRY_W = 16 + 2 * ADDR_BITS;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_CLOSE     = 3'd2;
   localparam logic [2:0] S_SHIFT     = 3'd3;
   localparam logic [2:0] S_INSERT    = 3'd4;
   localparam logic [2:0] S_ROOT_RD   = 3'd5;
   localparam logic [2:0] S_ROOT_WAIT = 3'd6;
   localparam logic [2:0] S_OUT       = 3'd7;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       status_ff, status_in;
   logic [7:0]       tdev_ff, tdev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_addr_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_entry;
   logic               match_hit;
   logic [7:0]         match_device;
   logic [CNT_W-1:0]   idx_inc;
   logic [CNT_W-1:0]   idx_dec;
   logic [CNT_W-1:0]   count_dec;
   logic               more_up;
   logic               is_access;
   logic               is_remove;
   logic [ADDR_BITS-1:0] addr_key;

   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign more_up   = (idx_ff < count_ff);
   assign is_remove = (req_ff.operation == OP_REMOVE);
   assign addr_key  = ADDR_BITS'(req_ff.address);

   always_comb begin
      case (req_ff.operation)
         OP_RD_BYTE, OP_RD_WORD, OP_WR_BYTE, OP_WR_WORD: is_access = 1'b1;
         default: is_access = 1'b0;
      endcase
   end

   pard_table #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   pard_match #(
      .ADDR_BITS (ADDR_BITS)
   ) u_match (
      .entry    (rd_entry),
      .by_id    (is_remove),
      .key_id   (req_ff.mapping_id),
      .key_addr (addr_key),
      .hit      (match_hit),
      .device   (match_device)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      tdev_in      = tdev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = rd_addr_ff;
      wr_data      = rd_entry;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = ST_OK;
               tdev_in   = '0;
               idx_in    = '0;
               case (req_data.operation)
                  OP_ADD: begin
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        status_in = ST_FULL;
                        state_in  = S_ROOT_RD;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_SHIFT;
                     end
                  end
                  OP_REMOVE, OP_RD_BYTE, OP_RD_WORD, OP_WR_BYTE, OP_WR_WORD: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_ROOT_RD;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Reads run one entry ahead of the compare.
            rd_en = more_up;
            if (more_up) begin
               idx_in = idx_inc;
            end
            if (rd_valid_ff && match_hit) begin
               if (is_remove) begin
                  state_in = S_CLOSE;
               end else begin
                  tdev_in  = match_device;
                  state_in = S_ROOT_RD;
               end
            end else if (!more_up) begin
               status_in = is_remove ? ST_NO_ID : ST_UNMAPPED;
               state_in  = S_ROOT_RD;
            end
         end
         S_CLOSE: begin
            rd_en = more_up;
            if (more_up) begin
               idx_in = idx_inc;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff - IDX_W'(1);
            end
            if (!more_up) begin
               count_in = count_dec;
               state_in = S_ROOT_RD;
            end
         end
         S_SHIFT: begin
            rd_en   = (idx_ff != '0);
            rd_addr = idx_dec[IDX_W-1:0];
            if (idx_ff != '0) begin
               idx_in = idx_dec;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_addr_ff + IDX_W'(1);
            end
            if (idx_ff == '0) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {req_ff.mapping_id, req_ff.device_id,
                        ADDR_BITS'(req_ff.range_start), ADDR_BITS'(req_ff.range_end)};
            count_in = count_ff + CNT_W'(1);
            state_in = S_ROOT_RD;
         end
         S_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = (count_ff == '0) ? '0 : count_dec[IDX_W-1:0];
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            rsp_in.status         = status_ff;
            rsp_in.target_device  = tdev_ff;
            rsp_in.access_kind    = '0;
            rsp_in.access_address = '0;
            rsp_in.access_data    = '0;
            if (is_access && status_ff == ST_OK) begin
               rsp_in.access_kind    = 2'(req_ff.operation - OP_RD_BYTE);
               rsp_in.access_address = 16'(addr_key);
               if (req_ff.operation == OP_WR_BYTE) begin
                  rsp_in.access_data = {8'h00, req_ff.write_data[7:0]};
               end else if (req_ff.operation == OP_WR_WORD) begin
                  rsp_in.access_data = req_ff.write_data;
               end
            end
            rsp_in.root_device  = (count_ff == '0) ? 8'h00 : match_device;
            rsp_in.entries_used = 5'(count_ff);
            rsp_valid_in        = 1'b1;
            state_in            = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      tdev_ff    <= tdev_in;
      rsp_ff     <= rsp_in;
      rd_addr_ff <= rd_addr;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("transaction accepted but sequencer stayed idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table depth");

   a_count_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INSERT && state_ff != S_CLOSE) |=> $stable(count_ff))
      else $error("entry count changed outside insert or close");

   a_valid_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT))
      else $error("result valid outside the output state");

endmodule
